/* hdl/lasm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lasm_pkg: shared types and constants of the LRU app slot manager
// Slot count, field widths, operation / status / action codes, FSM states.
// ----------------------------------------------------------------------------
package lasm_pkg;

    localparam int SLOTS       = 4;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int APP_W       = 8;
    localparam int TIME_W      = 32;
    localparam int IDX_OUT_W   = 4;
    localparam int LIVE_W      = 5;
    localparam int IN_TUSER_W  = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_USED_W  = 28;

    typedef enum logic [1:0] {
        OP_LAUNCH = 2'd0,
        OP_HOME   = 2'd1,
        OP_EVICT  = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NOT_FOUND     = 2'd1,
        ST_NO_SPACE      = 2'd2,
        ST_LAUNCH_FAILED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ACT_NONE         = 3'd0,
        ACT_RESUMED      = 3'd1,
        ACT_LAUNCHED     = 3'd2,
        ACT_MODAL_CLOSED = 3'd3,
        ACT_WENT_HOME    = 3'd4,
        ACT_ALREADY_FG   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic prep;   // latch item, suspend foreground if needed
        logic exec;   // apply operation, load result register
    } dp_cmd_t;

endpackage
`default_nettype wire

/* hdl/lasm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lasm_ctrl: sequencing FSM
// Takes one item, runs prep then exec, owns the result valid flag.
// ----------------------------------------------------------------------------
module lasm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output lasm_pkg::dp_cmd_t cmd
);
    import lasm_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.prep   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // result slot must be free (or emptying this cycle)
                if (!out_valid_reg || m_tready)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/lasm_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lasm_dp: slot table datapath
// Slot lanes, foreground/time registers, victim select, result register.
// ----------------------------------------------------------------------------
module lasm_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lasm_pkg::dp_cmd_t                   cmd,
    input  logic [lasm_pkg::IN_TUSER_W-1:0]     in_user,
    input  logic [lasm_pkg::IN_TDATA_W-1:0]     in_data,
    output logic [lasm_pkg::OUT_TDATA_W-1:0]    out_data
);
    import lasm_pkg::*;

    // slot table
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [APP_W-1:0]  app_reg  [SLOTS];
    logic [APP_W-1:0]  app_next [SLOTS];
    logic [TIME_W-1:0] time_reg  [SLOTS];
    logic [TIME_W-1:0] time_next [SLOTS];
    logic              fg_present_reg, fg_present_next;
    logic [SLOT_W-1:0] fg_idx_reg, fg_idx_next;
    logic [TIME_W-1:0] cur_time_reg, cur_time_next;

    // latched item
    op_t               op_reg, op_next;
    logic [APP_W-1:0]  id_reg, id_next;
    logic              known_reg, known_next;
    logic              ok_reg, ok_next;
    logic              modal_reg, modal_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              pre_fg_reg, pre_fg_next;
    logic              pre_already_reg, pre_already_next;

    logic [OUT_TDATA_W-1:0] out_reg, out_next;

    // input fields
    op_t               in_op;
    logic [APP_W-1:0]  in_id;
    logic              in_known, in_ok, in_modal;
    logic [TIME_W-1:0] in_now;

    assign in_op    = op_t'(in_user);
    assign in_id    = in_data[7:0];
    assign in_known = in_data[8];
    assign in_ok    = in_data[9];
    assign in_modal = in_data[10];
    assign in_now   = in_data[42:11];

    // per-lane decode
    logic [SLOTS-1:0]  fg_oh, in_match, warm_hit, free_slot, cand, win;
    logic              already, do_suspend;
    logic              warm_any, free_any, cand_any;
    logic [SLOT_W-1:0] warm_idx, free_idx, victim_idx;
    logic [APP_W-1:0]  victim_app;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            fg_oh[i]     = fg_present_reg && (fg_idx_reg == SLOT_W'(i));
            in_match[i]  = valid_reg[i] && (app_reg[i] == in_id);
            warm_hit[i]  = valid_reg[i] && (app_reg[i] == id_reg);
            free_slot[i] = !valid_reg[i];
            cand[i]      = valid_reg[i] && !fg_oh[i];
        end
    end

    assign already    = |(fg_oh & in_match);
    assign do_suspend = cmd.prep &&
                        (((in_op == OP_LAUNCH) && in_known && !already) ||
                         ((in_op == OP_HOME) && !in_modal));

    // oldest background slot; equal times go to the higher index
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            win[i] = cand[i];
            for (int j = 0; j < SLOTS; j++)
            begin
                if (j < i && cand[j] && (time_reg[i] > time_reg[j]))
                begin
                    win[i] = 1'b0;
                end
                if (j > i && cand[j] && (time_reg[i] >= time_reg[j]))
                begin
                    win[i] = 1'b0;
                end
            end
        end
    end

    // lowest-index encoders and victim mux
    always_comb
    begin
        warm_idx   = '0;
        free_idx   = '0;
        victim_idx = '0;
        victim_app = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (warm_hit[i])
            begin
                warm_idx = SLOT_W'(i);
            end
            if (free_slot[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (win[i])
            begin
                victim_idx = SLOT_W'(i);
                victim_app = victim_app | app_reg[i];
            end
        end
    end

    assign warm_any = |warm_hit;
    assign free_any = |free_slot;
    assign cand_any = |cand;

    // next state and result
    status_t           res_status;
    action_t           res_action;
    logic              ev_valid;
    logic [SLOT_W-1:0] ev_slot;
    logic [APP_W-1:0]  ev_app;
    logic [SLOT_W-1:0] tgt;
    logic [CNT_W-1:0]  live;

    always_comb
    begin
        valid_next       = valid_reg;
        app_next         = app_reg;
        time_next        = time_reg;
        fg_present_next  = fg_present_reg;
        fg_idx_next      = fg_idx_reg;
        cur_time_next    = cur_time_reg;
        op_next          = op_reg;
        id_next          = id_reg;
        known_next       = known_reg;
        ok_next          = ok_reg;
        modal_next       = modal_reg;
        now_next         = now_reg;
        pre_fg_next      = pre_fg_reg;
        pre_already_next = pre_already_reg;
        res_status       = ST_OK;
        res_action       = ACT_NONE;
        ev_valid         = 1'b0;
        ev_slot          = '0;
        ev_app           = '0;
        tgt              = free_any ? free_idx : victim_idx;

        if (cmd.prep)
        begin
            op_next          = in_op;
            id_next          = in_id;
            known_next       = in_known;
            ok_next          = in_ok;
            modal_next       = in_modal;
            now_next         = in_now;
            pre_fg_next      = fg_present_reg;
            pre_already_next = already;
            if (do_suspend)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (fg_oh[i])
                    begin
                        time_next[i] = cur_time_reg;
                    end
                end
                fg_present_next = 1'b0;
                fg_idx_next     = '0;
            end
        end

        if (cmd.exec)
        begin
            case (op_reg)
                OP_LAUNCH:
                begin
                    if (!known_reg)
                    begin
                        res_status = ST_NOT_FOUND;
                    end
                    else if (pre_already_reg)
                    begin
                        res_action = ACT_ALREADY_FG;
                    end
                    else if (warm_any)
                    begin
                        time_next[warm_idx] = cur_time_reg;
                        fg_present_next     = 1'b1;
                        fg_idx_next         = warm_idx;
                        res_action          = ACT_RESUMED;
                    end
                    else if (free_any || cand_any)
                    begin
                        if (!free_any)
                        begin
                            ev_valid = 1'b1;
                            ev_slot  = victim_idx;
                            ev_app   = victim_app;
                        end
                        if (ok_reg)
                        begin
                            valid_next[tgt] = 1'b1;
                            app_next[tgt]   = id_reg;
                            time_next[tgt]  = cur_time_reg;
                            fg_present_next = 1'b1;
                            fg_idx_next     = tgt;
                            res_action      = ACT_LAUNCHED;
                        end
                        else
                        begin
                            // start hook failed: slot closed again
                            valid_next[tgt] = 1'b0;
                            app_next[tgt]   = '0;
                            time_next[tgt]  = '0;
                            res_status      = ST_LAUNCH_FAILED;
                        end
                    end
                    else
                    begin
                        res_status = ST_NO_SPACE;
                    end
                end
                OP_HOME:
                begin
                    if (modal_reg)
                    begin
                        res_action = ACT_MODAL_CLOSED;
                    end
                    else if (pre_fg_reg)
                    begin
                        res_action = ACT_WENT_HOME;
                    end
                end
                OP_EVICT:
                begin
                    if (cand_any)
                    begin
                        ev_valid               = 1'b1;
                        ev_slot                = victim_idx;
                        ev_app                 = victim_app;
                        valid_next[victim_idx] = 1'b0;
                        app_next[victim_idx]   = '0;
                        time_next[victim_idx]  = '0;
                    end
                end
                OP_TICK:
                begin
                    cur_time_next = now_reg;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (fg_oh[i])
                        begin
                            time_next[i] = now_reg;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        live = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            live = live + CNT_W'(valid_next[i]);
        end

        out_next = out_reg;
        if (cmd.exec)
        begin
            out_next = {
                (OUT_TDATA_W - OUT_USED_W)'(0),
                LIVE_W'(live),
                ev_app,
                IDX_OUT_W'(ev_slot),
                ev_valid,
                fg_present_next ? IDX_OUT_W'(fg_idx_next) : IDX_OUT_W'(0),
                fg_present_next,
                res_action,
                res_status
            };
        end
    end

    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            fg_present_reg <= 1'b0;
            fg_idx_reg     <= '0;
            cur_time_reg   <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                app_reg[i]  <= '0;
                time_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg      <= valid_next;
            fg_present_reg <= fg_present_next;
            fg_idx_reg     <= fg_idx_next;
            cur_time_reg   <= cur_time_next;
            app_reg        <= app_next;
            time_reg       <= time_next;
        end
    end

    // item and result payload, no reset
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        id_reg          <= id_next;
        known_reg       <= known_next;
        ok_reg          <= ok_next;
        modal_reg       <= modal_next;
        now_reg         <= now_next;
        pre_fg_reg      <= pre_fg_next;
        pre_already_reg <= pre_already_next;
        out_reg         <= out_next;
    end

endmodule
`default_nettype wire

/* hdl/lru_app_slot_manager.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_app_slot_manager: app slot table with LRU eviction and a pinned
// foreground slot
// ----------------------------------------------------------------------------
// Usage:
//  - Commands enter on the s_axis channel: operation in tuser (launch, go
//    home, memory-pressure evict, tick), arguments in tdata.
//  - Every command yields exactly one result item on m_axis: status,
//    action, foreground slot, eviction report and live slot count.
//  - Timing: a command is taken in prep (latch, suspend the foreground
//    slot when needed) and applied in exec (slot search, victim select,
//    table update). The result is registered at exec; the next command
//    is taken only after the previous one has left exec.
//  - The victim select compares all slot timestamps pairwise in parallel,
//    so exec needs no iteration for any slot count.
//  - The result sits in an output register; s_axis_tready returns high
//    right after exec, so the next command is taken while the result waits.
//    A command reaching exec while the result register is still held waits
//    there until m_axis_tready drains it.
//  - Reset (rst_n low, async): all slots empty, no foreground, time zero,
//    no pending result.
// ----------------------------------------------------------------------------
module lru_app_slot_manager
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] app_id, [8] app_known, [9] launch_ok, [10] modal_open,
    // [42:11] now_ms, [47:43] zero
    input  logic [47:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [4:2] action, [5] fg_valid, [9:6] fg_slot,
    // [10] evicted_valid, [14:11] evicted_slot, [22:15] evicted_app,
    // [27:23] live_count, [31:28] zero
    output logic [31:0] m_axis_tdata
);
    import lasm_pkg::*;

    dp_cmd_t cmd;

    lasm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .cmd      (cmd)
    );

    lasm_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_user  (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata)
    );

endmodule
`default_nettype wire

/* hdl/lasm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lasm_checker: port-level assertions for the slot manager
// Bound onto the top level.
// ----------------------------------------------------------------------------
module lasm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    import lasm_pkg::*;

    // held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // one command in flight
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted during exec");

    a_live_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[27:23] <= LIVE_W'(SLOTS)))
        else $error("live count above slot count");

    // unknown app changes nothing and reports nothing
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == ST_NOT_FOUND) |->
        (m_axis_tdata[4:2] == ACT_NONE) && !m_axis_tdata[10])
        else $error("not-found result with side effects");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
        (m_axis_tdata[5] || (m_axis_tdata[9:6] == 4'd0)) &&
        (m_axis_tdata[10] || (m_axis_tdata[22:11] == 12'd0)))
        else $error("invalid index fields not zero");

endmodule

bind lru_app_slot_manager lasm_checker u_lasm_checker (.*);
`default_nettype wire
